>>> sv/assert_macros.svh
// Assertion macros shared by the histogram engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever ante holds at a clock edge, cons must hold at the same edge.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

>>> sv/edh_pkg.sv
// Types, constants and helpers shared by the histogram engine modules.
package edh_pkg;

  localparam int MAX_BINS  = 64;
  localparam int IDX_W     = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int CNT_W     = $clog2(MAX_BINS + 1);
  localparam int KEY_W     = 32;
  localparam int OCC_W     = 32;
  localparam int HGT_W     = 48;
  localparam int DV_W      = 20;
  localparam int MB_W      = 7;
  localparam int BIN_W     = 6;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 1;
  localparam int DIVC_W    = $clog2(DV_W + 1);

  localparam logic [CFG_IDX_W-1:0] REG_MAX_BINS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISTINCT = 1'd1;

  localparam logic [MB_W-1:0] MAX_BINS_RST = MB_W'(64);
  localparam logic [DV_W-1:0] DISTINCT_RST = DV_W'(1);

  localparam logic ANS_BIN    = 1'b0;
  localparam logic ANS_LOOKUP = 1'b1;

  typedef enum logic {
    REQ_BUILD  = 1'b0,
    REQ_LOOKUP = 1'b1
  } req_kind_t;

  typedef struct packed {
    req_kind_t               kind;
    logic signed [KEY_W-1:0] key;
    logic [OCC_W-1:0]        occ;
    logic                    fin;
  } item_t;

  // Head of the queue between the front and the back.
  typedef struct packed {
    logic  valid;
    item_t item;
  } qhead_t;

  typedef struct packed {
    logic                    kind;
    logic [BIN_W-1:0]        bin_number;
    logic signed [KEY_W-1:0] bin_low;
    logic signed [KEY_W-1:0] bin_high;
    logic [HGT_W-1:0]        bin_total;
    logic [DV_W-1:0]         bin_distinct;
    logic                    found;
    logic [BIN_W-1:0]        next_bin;
    logic                    next_found;
    logic                    last_bin;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_BUILD,
    ST_SEARCH,
    ST_FETCH,
    ST_EMIT
  } state_t;

  // Bin indexes are reported modulo the width of the bin number field.
  function automatic logic [BIN_W-1:0] bin_field(input logic [CNT_W-1:0] v);
    return BIN_W'(32'(v));
  endfunction

endpackage

>>> sv/edh_front.sv
// Front end: accepts input beats, classifies them and queues them for the back end.
module edh_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_req_type,
  input  logic signed [edh_pkg::KEY_W-1:0] in_key_value,
  input  logic [edh_pkg::OCC_W-1:0]       in_occurrences,
  input  logic                            in_final_pair,
  input  logic                            pop,
  output edh_pkg::qhead_t                 head
);
  import edh_pkg::*;

  localparam int QDEPTH = 2;

  item_t      q_mem_r [QDEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  item_t      new_item;

  assign in_stall = (cnt_r == 2'(QDEPTH));
  assign push     = in_valid && !in_stall;

  always_comb begin
    new_item.kind = in_req_type ? REQ_LOOKUP : REQ_BUILD;
    new_item.key  = in_key_value;
    new_item.occ  = in_occurrences;
    new_item.fin  = in_final_pair;
  end

  assign head.valid = (cnt_r != 2'd0);
  assign head.item  = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

>>> sv/edh_div.sv
// Restoring divider, one quotient bit per cycle, for the bin layout of a build.
module edh_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [edh_pkg::DV_W-1:0]  dividend,
  input  logic [edh_pkg::CNT_W-1:0] divisor,
  output logic                      done,
  output logic [edh_pkg::DV_W-1:0]  quotient,
  output logic [edh_pkg::CNT_W-1:0] remainder
);
  import edh_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIVC_W-1:0] cnt_r, cnt_nxt;
  logic [DV_W-1:0]   quo_r, quo_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  dsr_r, dsr_nxt;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              ge;

  assign trial = {rem_r, quo_r[DV_W-1]};
  assign ge    = (trial >= {1'b0, dsr_r});
  assign diff  = trial - {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIVC_W'(DV_W);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      // The dividend shifts out of the top of quo_r as quotient bits shift in.
      quo_nxt = {quo_r[DV_W-2:0], ge};
      rem_nxt = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      cnt_nxt = cnt_r - DIVC_W'(1);
      if (cnt_r == DIVC_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

>>> sv/edh_back.sv
// Back end: builds the bins, holds the bin stores, searches them and drives results.
module edh_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  edh_pkg::qhead_t          head,
  output logic                     pop,
  input  logic [edh_pkg::MB_W-1:0] cfg_max_bins,
  input  logic [edh_pkg::DV_W-1:0] cfg_distinct,
  output logic                     out_valid,
  input  logic                     out_stall,
  output edh_pkg::res_t            out_res
);
  import edh_pkg::*;

  state_t                  state_r, state_nxt;
  item_t                   cur_r, cur_nxt;
  logic [CNT_W-1:0]        biu_r, biu_nxt;
  logic [DV_W-1:0]         share_r, share_nxt;
  logic [IDX_W-1:0]        extra_r, extra_nxt;
  logic [IDX_W-1:0]        bidx_r, bidx_nxt;
  logic [DV_W-1:0]         vib_r, vib_nxt;
  logic [HGT_W-1:0]        runh_r, runh_nxt;
  logic signed [KEY_W-1:0] runmin_r, runmin_nxt;
  logic                    ready_r, ready_nxt;
  logic [CNT_W-1:0]        lo_a_r, lo_a_nxt, hi_a_r, hi_a_nxt;
  logic [CNT_W-1:0]        lo_b_r, lo_b_nxt, hi_b_r, hi_b_nxt;
  logic [IDX_W-1:0]        mid_a_r, mid_a_nxt, mid_b_r, mid_b_nxt;
  res_t                    res_r, res_nxt;
  res_t                    out_r, out_nxt;
  logic                    out_valid_r, out_valid_nxt;

  logic signed [KEY_W-1:0] min_mem [MAX_BINS];
  logic signed [KEY_W-1:0] max_mem [MAX_BINS];
  logic [HGT_W-1:0]        hgt_mem [MAX_BINS];
  logic signed [KEY_W-1:0] rd_min_r, rd_max_a_r, rd_max_b_r;
  logic [HGT_W-1:0]        rd_hgt_r;
  logic [IDX_W-1:0]        rd_addr_a, rd_addr_b;
  logic                    mem_we;
  logic [IDX_W-1:0]        mem_waddr;
  logic signed [KEY_W-1:0] mem_wmin, mem_wmax;
  logic [HGT_W-1:0]        mem_whgt;

  logic                    div_start, div_done;
  logic [DV_W-1:0]         div_quo;
  logic [CNT_W-1:0]        div_rem;
  logic [DV_W-1:0]         mb_eff, dv_eff, bins_eff;
  logic [CNT_W-1:0]        bins_start;

  logic                    out_free;
  logic [DV_W-1:0]         vib_inc;
  logic [HGT_W:0]          hsum;
  logic [HGT_W-1:0]        hsat;
  logic signed [KEY_W-1:0] bmin;
  logic [DV_W:0]           target;
  logic                    close_bin, last;
  logic [CNT_W-1:0]        lo_a_s, hi_a_s, lo_b_s, hi_b_s;
  logic [CNT_W:0]          sum_a, sum_b;
  logic                    act_a, act_b;

  edh_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (dv_eff),
    .divisor   (bins_start),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Bin layout of a new build, from the registers with their out-of-range values folded.
  always_comb begin
    mb_eff = DV_W'(cfg_max_bins);
    if (mb_eff == '0) begin
      mb_eff = DV_W'(1);
    end else if (mb_eff > DV_W'(MAX_BINS)) begin
      mb_eff = DV_W'(MAX_BINS);
    end
    dv_eff     = (cfg_distinct == '0) ? DV_W'(1) : cfg_distinct;
    bins_eff   = (dv_eff < mb_eff) ? dv_eff : mb_eff;
    bins_start = CNT_W'(bins_eff);
  end

  // Accumulation of one build pair into the open bin.
  always_comb begin
    vib_inc   = vib_r + DV_W'(1);
    hsum      = {1'b0, runh_r} + (HGT_W+1)'(cur_r.occ);
    hsat      = hsum[HGT_W] ? {HGT_W{1'b1}} : hsum[HGT_W-1:0];
    bmin      = (vib_r == '0) ? cur_r.key : runmin_r;
    target    = {1'b0, share_r} + (DV_W+1)'(bidx_r < extra_r);
    close_bin = ({1'b0, vib_inc} >= target) || cur_r.fin;
    last      = cur_r.fin || ((CNT_W'(bidx_r) + CNT_W'(1)) >= biu_r);
  end

  // One step of both binary searches: lower bound (a) and strict upper bound (b).
  always_comb begin
    act_a  = (lo_a_r < hi_a_r);
    act_b  = (lo_b_r < hi_b_r);
    lo_a_s = lo_a_r;
    hi_a_s = hi_a_r;
    lo_b_s = lo_b_r;
    hi_b_s = hi_b_r;
    if (act_a) begin
      if (rd_max_a_r < cur_r.key) begin
        lo_a_s = CNT_W'(mid_a_r) + CNT_W'(1);
      end else begin
        hi_a_s = CNT_W'(mid_a_r);
      end
    end
    if (act_b) begin
      if (rd_max_b_r <= cur_r.key) begin
        lo_b_s = CNT_W'(mid_b_r) + CNT_W'(1);
      end else begin
        hi_b_s = CNT_W'(mid_b_r);
      end
    end
    sum_a = {1'b0, lo_a_s} + {1'b0, hi_a_s};
    sum_b = {1'b0, lo_b_s} + {1'b0, hi_b_s};
  end

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    biu_nxt       = biu_r;
    share_nxt     = share_r;
    extra_nxt     = extra_r;
    bidx_nxt      = bidx_r;
    vib_nxt       = vib_r;
    runh_nxt      = runh_r;
    runmin_nxt    = runmin_r;
    ready_nxt     = ready_r;
    lo_a_nxt      = lo_a_r;
    hi_a_nxt      = hi_a_r;
    lo_b_nxt      = lo_b_r;
    hi_b_nxt      = hi_b_r;
    mid_a_nxt     = mid_a_r;
    mid_b_nxt     = mid_b_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    pop           = 1'b0;
    div_start     = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = bidx_r;
    mem_wmin      = bmin;
    mem_wmax      = cur_r.key;
    mem_whgt      = hsat;
    rd_addr_a     = mid_a_r;
    rd_addr_b     = mid_b_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (head.valid) begin
          pop     = 1'b1;
          cur_nxt = head.item;
          if (head.item.kind == REQ_BUILD) begin
            if (bidx_r == '0 && vib_r == '0) begin
              biu_nxt   = bins_start;
              div_start = 1'b1;
              state_nxt = ST_DIV;
            end else begin
              state_nxt = ST_BUILD;
            end
          end else if (ready_r && biu_r != '0) begin
            lo_a_nxt  = '0;
            hi_a_nxt  = biu_r;
            lo_b_nxt  = '0;
            hi_b_nxt  = biu_r;
            mid_a_nxt = IDX_W'(biu_r >> 1);
            mid_b_nxt = IDX_W'(biu_r >> 1);
            rd_addr_a = IDX_W'(biu_r >> 1);
            rd_addr_b = IDX_W'(biu_r >> 1);
            state_nxt = ST_SEARCH;
          end else begin
            // No finished histogram: the answer says nothing was found.
            res_nxt      = '0;
            res_nxt.kind = ANS_LOOKUP;
            state_nxt    = ST_EMIT;
          end
        end
      end

      ST_DIV: begin
        if (div_done) begin
          share_nxt = div_quo;
          extra_nxt = IDX_W'(div_rem);
          ready_nxt = 1'b0;
          runh_nxt  = '0;
          state_nxt = ST_BUILD;
        end
      end

      ST_BUILD: begin
        if (close_bin) begin
          mem_we               = 1'b1;
          res_nxt              = '0;
          res_nxt.kind         = ANS_BIN;
          res_nxt.bin_number   = bin_field(CNT_W'(bidx_r));
          res_nxt.bin_low      = bmin;
          res_nxt.bin_high     = cur_r.key;
          res_nxt.bin_total    = hsat;
          res_nxt.bin_distinct = share_r + DV_W'(bidx_r < extra_r);
          res_nxt.last_bin     = last;
          vib_nxt              = '0;
          runh_nxt             = '0;
          runmin_nxt           = bmin;
          if (last) begin
            biu_nxt   = CNT_W'(bidx_r) + CNT_W'(1);
            bidx_nxt  = '0;
            ready_nxt = 1'b1;
          end else begin
            bidx_nxt = bidx_r + IDX_W'(1);
          end
          state_nxt = ST_EMIT;
        end else begin
          vib_nxt    = vib_inc;
          runh_nxt   = hsat;
          runmin_nxt = bmin;
          state_nxt  = ST_IDLE;
        end
      end

      ST_SEARCH: begin
        lo_a_nxt = lo_a_s;
        hi_a_nxt = hi_a_s;
        lo_b_nxt = lo_b_s;
        hi_b_nxt = hi_b_s;
        if (!(lo_a_s < hi_a_s) && !(lo_b_s < hi_b_s)) begin
          // Both bounds settled: fetch the lower-bound bin from all stores.
          rd_addr_a = IDX_W'(lo_a_s);
          state_nxt = ST_FETCH;
        end else begin
          mid_a_nxt = IDX_W'(sum_a >> 1);
          mid_b_nxt = IDX_W'(sum_b >> 1);
          rd_addr_a = IDX_W'(sum_a >> 1);
          rd_addr_b = IDX_W'(sum_b >> 1);
        end
      end

      ST_FETCH: begin
        res_nxt      = '0;
        res_nxt.kind = ANS_LOOKUP;
        if (lo_a_r < biu_r) begin
          res_nxt.bin_number   = bin_field(lo_a_r);
          res_nxt.bin_low      = rd_min_r;
          res_nxt.bin_high     = rd_max_a_r;
          res_nxt.bin_total    = rd_hgt_r;
          res_nxt.bin_distinct = share_r + DV_W'(lo_a_r < CNT_W'(extra_r));
          res_nxt.found        = (cur_r.key >= rd_min_r) && (cur_r.key <= rd_max_a_r);
        end
        if (lo_b_r < biu_r) begin
          res_nxt.next_bin   = bin_field(lo_b_r);
          res_nxt.next_found = 1'b1;
        end
        state_nxt = ST_EMIT;
      end

      ST_EMIT: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      biu_r       <= '0;
      share_r     <= '0;
      extra_r     <= '0;
      bidx_r      <= '0;
      vib_r       <= '0;
      runh_r      <= '0;
      runmin_r    <= '0;
      ready_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      biu_r       <= biu_nxt;
      share_r     <= share_nxt;
      extra_r     <= extra_nxt;
      bidx_r      <= bidx_nxt;
      vib_r       <= vib_nxt;
      runh_r      <= runh_nxt;
      runmin_r    <= runmin_nxt;
      ready_r     <= ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    lo_a_r  <= lo_a_nxt;
    hi_a_r  <= hi_a_nxt;
    lo_b_r  <= lo_b_nxt;
    hi_b_r  <= hi_b_nxt;
    mid_a_r <= mid_a_nxt;
    mid_b_r <= mid_b_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
  end

  // Bin stores: one write port, registered reads at two addresses for the maxima.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      min_mem[mem_waddr] <= mem_wmin;
      max_mem[mem_waddr] <= mem_wmax;
      hgt_mem[mem_waddr] <= mem_whgt;
    end
    rd_min_r   <= min_mem[rd_addr_a];
    rd_max_a_r <= max_mem[rd_addr_a];
    rd_hgt_r   <= hgt_mem[rd_addr_a];
    rd_max_b_r <= max_mem[rd_addr_b];
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

>>> sv/equal_distinct_histogram_engine.sv
// Top level of the equal-distinct-count histogram engine.
//
//   channel   direction  handshake             payload
//   in_       input      in_valid / in_stall   req_type, key_value, occurrences, final_pair
//   out_      output     out_valid / out_stall answer_kind, bin_*, found, next_*, last_bin
//   cfg_      input      cfg_we                cfg_index, cfg_wdata
//
// A build pair passes through ST_BUILD, and ST_EMIT too when it closes a bin; the first pair
// of a build first waits in ST_DIV on the 20-bit bit-serial divide that lays out the bins.
// A lookup steps a binary search over the maxima store, at most ceil(log2(bins + 1)) steps;
// the store read port sets the step.
// Reset is synchronous and active low; the bin stores hold garbage until a build writes them.
// A two-beat queue decouples intake from the back end, and a result register lets the
// back end finish the next beat while a result waits on out_stall.
`include "assert_macros.svh"

module equal_distinct_histogram_engine (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_req_type,
  input  logic signed [edh_pkg::KEY_W-1:0]    in_key_value,
  input  logic [edh_pkg::OCC_W-1:0]           in_occurrences,
  input  logic                                in_final_pair,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_answer_kind,
  output logic [edh_pkg::BIN_W-1:0]           out_bin_number,
  output logic signed [edh_pkg::KEY_W-1:0]    out_bin_low,
  output logic signed [edh_pkg::KEY_W-1:0]    out_bin_high,
  output logic [edh_pkg::HGT_W-1:0]           out_bin_total,
  output logic [edh_pkg::DV_W-1:0]            out_bin_distinct,
  output logic                                out_found,
  output logic [edh_pkg::BIN_W-1:0]           out_next_bin,
  output logic                                out_next_found,
  output logic                                out_last_bin,
  input  logic                                cfg_we,
  input  logic [edh_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [edh_pkg::CFG_W-1:0]           cfg_wdata
);
  import edh_pkg::*;

  logic [MB_W-1:0] cfg_max_bins_r, cfg_max_bins_nxt;
  logic [DV_W-1:0] cfg_distinct_r, cfg_distinct_nxt;
  qhead_t          head;
  logic            pop;
  res_t            res;

  always_comb begin
    cfg_max_bins_nxt = cfg_max_bins_r;
    cfg_distinct_nxt = cfg_distinct_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_BINS: cfg_max_bins_nxt = cfg_wdata[MB_W-1:0];
        REG_DISTINCT: cfg_distinct_nxt = cfg_wdata[DV_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_max_bins_r <= MAX_BINS_RST;
      cfg_distinct_r <= DISTINCT_RST;
    end else begin
      cfg_max_bins_r <= cfg_max_bins_nxt;
      cfg_distinct_r <= cfg_distinct_nxt;
    end
  end

  edh_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_key_value   (in_key_value),
    .in_occurrences (in_occurrences),
    .in_final_pair  (in_final_pair),
    .pop            (pop),
    .head           (head)
  );

  edh_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (head),
    .pop          (pop),
    .cfg_max_bins (cfg_max_bins_r),
    .cfg_distinct (cfg_distinct_r),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_res      (res)
  );

  assign out_answer_kind  = res.kind;
  assign out_bin_number   = res.bin_number;
  assign out_bin_low      = res.bin_low;
  assign out_bin_high     = res.bin_high;
  assign out_bin_total    = res.bin_total;
  assign out_bin_distinct = res.bin_distinct;
  assign out_found        = res.found;
  assign out_next_bin     = res.next_bin;
  assign out_next_found   = res.next_found;
  assign out_last_bin     = res.last_bin;

  `ASSERT_IMPLIES(a_found_in_range, out_valid && out_found, out_bin_low <= out_bin_high, "found bin has low above high")
  `ASSERT_NEVER(a_bin_beat_no_search, out_valid && out_answer_kind == ANS_BIN && (out_found || out_next_found), "build beat carries lookup flags")
  `ASSERT_NEVER(a_lookup_not_last, out_valid && out_answer_kind == ANS_LOOKUP && out_last_bin, "lookup beat marked as last bin")

endmodule

>>> test/tb_equal_distinct_histogram_engine.sv
// Self-checking testbench for the equal-distinct-count histogram engine.
module tb_equal_distinct_histogram_engine;
  import edh_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 64;
  localparam int LONG_HOLD     = 200;
  localparam logic [HGT_W-1:0] HEIGHT_CEILING = '1;

  logic                    clk   = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    in_req_type = 1'b0;
  logic signed [KEY_W-1:0] in_key_value = '0;
  logic [OCC_W-1:0]        in_occurrences = '0;
  logic                    in_final_pair = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    out_answer_kind;
  logic [BIN_W-1:0]        out_bin_number;
  logic signed [KEY_W-1:0] out_bin_low;
  logic signed [KEY_W-1:0] out_bin_high;
  logic [HGT_W-1:0]        out_bin_total;
  logic [DV_W-1:0]         out_bin_distinct;
  logic                    out_found;
  logic [BIN_W-1:0]        out_next_bin;
  logic                    out_next_found;
  logic                    out_last_bin;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_W-1:0]        cfg_wdata = '0;

  equal_distinct_histogram_engine dut (.*);

  always #5 clk = ~clk;

  // Shadow copy of the engine: registers, bin stores and build progress.
  logic [MB_W-1:0]         max_bins_reg = MAX_BINS_RST;
  logic [DV_W-1:0]         distinct_reg = DISTINCT_RST;
  logic signed [KEY_W-1:0] low_mem  [MAX_BINS];
  logic signed [KEY_W-1:0] high_mem [MAX_BINS];
  logic [HGT_W-1:0]        total_mem [MAX_BINS];
  int                      bins_used = 0;
  int                      share = 0;
  int                      extra = 0;
  int                      fill_bin = 0;
  int                      fill_count = 0;
  logic [HGT_W-1:0]        fill_height = '0;
  logic signed [KEY_W-1:0] fill_low = '0;
  bit                      histogram_valid = 1'b0;

  item_t             request_q[$];
  res_t              answer_q[$];
  logic [KEY_W-1:0]  built_keys[$];
  res_t              want;
  int                items_pushed = 0;
  int                mismatches = 0;
  int                cycle_count = 0;
  int                gap_left = 0;
  int                stall_left = 0;
  int                hold_left = 0;
  bit                hold_request = 1'b0;
  bit                calm = 1'b0;
  bit                beat_taken;

  // First bin whose maximum is >= probe, or > probe when strict.
  function automatic int maxima_bound(logic signed [KEY_W-1:0] probe, bit strict);
    int lo, hi, mid;
    lo = 0;
    hi = bins_used;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (strict ? (high_mem[mid] <= probe) : (high_mem[mid] < probe)) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic void histogram_predict(item_t it);
    res_t              r;
    logic [HGT_W:0]    sum;
    int                mb, dv, quota, lb, ub;
    bit                closing_last;
    r = '0;
    if (it.kind == REQ_BUILD) begin
      // A pair with no bin in progress lays out a fresh histogram.
      if (fill_bin == 0 && fill_count == 0) begin
        mb = int'(max_bins_reg);
        if (mb == 0) mb = 1;
        if (mb > MAX_BINS) mb = MAX_BINS;
        dv = int'(distinct_reg);
        if (dv == 0) dv = 1;
        bins_used = (dv < mb) ? dv : mb;
        share = dv / bins_used;
        extra = dv % bins_used;
        histogram_valid = 1'b0;
        fill_height = '0;
      end
      if (fill_count == 0) fill_low = it.key;
      fill_count++;
      sum = {1'b0, fill_height} + (HGT_W+1)'(it.occ);
      fill_height = (sum > {1'b0, HEIGHT_CEILING}) ? HEIGHT_CEILING : sum[HGT_W-1:0];
      quota = share + ((fill_bin < extra) ? 1 : 0);
      if (fill_count < quota && !it.fin) return;
      low_mem[fill_bin]   = fill_low;
      high_mem[fill_bin]  = it.key;
      total_mem[fill_bin] = fill_height;
      closing_last = it.fin || (fill_bin + 1 >= bins_used);
      r.kind         = ANS_BIN;
      r.bin_number   = BIN_W'(fill_bin);
      r.bin_low      = fill_low;
      r.bin_high     = it.key;
      r.bin_total    = fill_height;
      r.bin_distinct = DV_W'(quota);
      r.last_bin     = closing_last;
      fill_count  = 0;
      fill_height = '0;
      if (closing_last) begin
        bins_used = fill_bin + 1;
        fill_bin = 0;
        histogram_valid = 1'b1;
      end else begin
        fill_bin++;
      end
    end else begin
      r.kind = ANS_LOOKUP;
      if (histogram_valid && bins_used > 0) begin
        lb = maxima_bound(it.key, 1'b0);
        ub = maxima_bound(it.key, 1'b1);
        if (lb < bins_used) begin
          r.bin_number   = BIN_W'(lb);
          r.bin_low      = low_mem[lb];
          r.bin_high     = high_mem[lb];
          r.bin_total    = total_mem[lb];
          r.bin_distinct = DV_W'(share + ((lb < extra) ? 1 : 0));
          r.found        = (it.key >= low_mem[lb]) && (it.key <= high_mem[lb]);
        end
        if (ub < bins_used) begin
          r.next_bin   = BIN_W'(ub);
          r.next_found = 1'b1;
        end
      end
    end
    answer_q.push_back(r);
  endfunction

  task automatic compare_field(string name, logic [63:0] expected, logic [63:0] actual);
    if (expected !== actual) begin
      $error("%s: expected %0h, got %0h", name, expected, actual);
      mismatches++;
    end
  endtask

  // Input driver: a new beat is offered only once the previous one was taken.
  always @(posedge clk) begin
    if (rst_n) begin
      beat_taken = in_valid && !in_stall;
      if (beat_taken) histogram_predict(request_q.pop_front());
      if (!in_valid || beat_taken) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (!calm && request_q.size() != 0 && $urandom_range(0, 4) == 0) begin
          gap_left = $urandom_range(0, 2);
          in_valid <= 1'b0;
        end else if (request_q.size() != 0) begin
          in_req_type    <= request_q[0].kind;
          in_key_value   <= request_q[0].key;
          in_occurrences <= request_q[0].occ;
          in_final_pair  <= request_q[0].fin;
          in_valid       <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall generation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (answer_q.size() == 0) begin
          $error("result beat arrived with nothing expected");
          mismatches++;
        end else begin
          want = answer_q.pop_front();
          compare_field("answer_kind", 64'(want.kind), 64'(out_answer_kind));
          compare_field("bin_number", 64'(want.bin_number), 64'(out_bin_number));
          compare_field("bin_low", 64'(want.bin_low), 64'(out_bin_low));
          compare_field("bin_high", 64'(want.bin_high), 64'(out_bin_high));
          compare_field("bin_total", 64'(want.bin_total), 64'(out_bin_total));
          compare_field("bin_distinct", 64'(want.bin_distinct), 64'(out_bin_distinct));
          compare_field("found", 64'(want.found), 64'(out_found));
          compare_field("next_bin", 64'(want.next_bin), 64'(out_next_bin));
          compare_field("next_found", 64'(want.next_found), 64'(out_next_found));
          compare_field("last_bin", 64'(want.last_bin), 64'(out_last_bin));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL equal_distinct_histogram_engine");
      $finish;
    end
  end

  task automatic push_item(req_kind_t kind, logic [KEY_W-1:0] key, logic [OCC_W-1:0] occ,
                           logic fin);
    item_t it;
    it.kind = kind;
    it.key  = key;
    it.occ  = occ;
    it.fin  = fin;
    request_q.push_back(it);
    items_pushed++;
  endtask

  // Registers change only with the engine idle, so the shadow copy follows at once.
  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MAX_BINS) max_bins_reg = data[MB_W-1:0];
    else distinct_reg = data[DV_W-1:0];
    @(negedge clk);
  endtask

  task automatic wait_idle();
    while (request_q.size() != 0 || in_valid || answer_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic queue_lookups(int n);
    logic [KEY_W-1:0] probe, pick;
    for (int i = 0; i < n; i++) begin
      probe = $urandom;
      if (built_keys.size() != 0) begin
        pick = built_keys[$urandom_range(0, built_keys.size() - 1)];
        case ($urandom_range(0, 9))
          0, 1, 2, 3: probe = pick;
          4, 5:       probe = pick + 1;
          6:          probe = pick - 1;
          7:          probe = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
          default:    ;
        endcase
      end
      push_item(REQ_LOOKUP, probe, $urandom, 1'($urandom_range(0, 1)));
    end
  endtask

  // Keys climb in random steps sized so that n of them span the whole signed range, or are random when shuffled.
  task automatic queue_pairs(int n, bit final_on_last, bit shuffled, bit heavy,
                             int mid_lookups);
    longint           span, next_key;
    logic [KEY_W-1:0] key;
    logic [OCC_W-1:0] occ;
    built_keys.delete();
    span = 64'hFFFF_FFFF / 64'(n + 1);
    next_key = 64'shFFFF_FFFF_8000_0000 + 64'($urandom_range(0, 32'(span - 1)));
    for (int i = 0; i < n; i++) begin
      if (mid_lookups != 0 && i == n / 2) queue_lookups(mid_lookups);
      key = shuffled ? $urandom : next_key[KEY_W-1:0];
      next_key = next_key + 64'(1) + 64'($urandom_range(0, 32'(span - 1)));
      case ($urandom_range(0, 7))
        0:       occ = '0;
        1:       occ = '1;
        default: occ = $urandom;
      endcase
      if (heavy) occ = '1;
      built_keys.push_back(key);
      push_item(REQ_BUILD, key, occ, final_on_last && i == n - 1);
    end
  endtask

  task automatic random_phase(int phase);
    logic [CFG_W-1:0] mb_data, dv_data;
    int               dv_eff, n, mode;
    bit               fin_last;
    case (phase)
      0: begin mb_data = 20'd0;   dv_data = 20'd7; end
      1: begin mb_data = 20'd127; dv_data = 20'd0; end
      2: begin mb_data = 20'd64;  dv_data = 20'hFFFFF; end
      3: begin mb_data = 20'd1;   dv_data = 20'd1; end
      4: begin mb_data = 20'd70;  dv_data = 20'd130; end
      default: begin
        case ($urandom_range(0, 9))
          0:       mb_data = 20'd0;
          1:       mb_data = 20'd1;
          2:       mb_data = 20'd64;
          3:       mb_data = CFG_W'($urandom_range(65, 127));
          default: mb_data = CFG_W'($urandom_range(2, 12));
        endcase
        // Bits above the register width must be dropped by the engine.
        if ($urandom_range(0, 3) == 0) mb_data = mb_data | CFG_W'($urandom & 32'hFFF80);
        case ($urandom_range(0, 9))
          0:       dv_data = 20'd0;
          1:       dv_data = 20'd1;
          2:       dv_data = CFG_W'($urandom_range(150, 32'hFFFFF));
          3:       dv_data = CFG_W'($urandom_range(40, 100));
          default: dv_data = CFG_W'($urandom_range(2, 30));
        endcase
      end
    endcase
    case ((phase < 5) ? 0 : $urandom_range(0, 5))
      1:       write_cfg(REG_MAX_BINS, mb_data);
      2:       write_cfg(REG_DISTINCT, dv_data);
      default: begin
        write_cfg(REG_MAX_BINS, mb_data);
        write_cfg(REG_DISTINCT, dv_data);
      end
    endcase
    dv_eff = (distinct_reg == '0) ? 1 : int'(distinct_reg);
    n = dv_eff;
    fin_last = 1'($urandom_range(0, 1));
    mode = (phase < 5) ? 9 : $urandom_range(0, 9);
    if (n > 150) begin
      n = $urandom_range(1, 40);
      fin_last = 1'b1;
    end else if (mode == 0 && n > 1) begin
      n = $urandom_range(1, n - 1);
      fin_last = 1'b1;
    end else if (mode == 1) begin
      // Run past the layout so a second build starts, then cut it short.
      n = n + $urandom_range(1, 3);
      fin_last = 1'b1;
    end
    queue_pairs(n, fin_last, mode == 2, 1'b0, (mode == 3) ? $urandom_range(1, 4) : 0);
    queue_lookups((phase == 4) ? 24 : $urandom_range(4, 16));
    if (phase == 4) hold_request = 1'b1;
    wait_idle();
  endtask

  initial begin
    int phase;
    int stop_at;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Nothing has been built yet.
    push_item(REQ_LOOKUP, 32'd0, 32'd0, 1'b0);
    wait_idle();

    // Four bins of 3, 3, 2 and 2 values spanning the key extremes.
    write_cfg(REG_MAX_BINS, 20'd4);
    write_cfg(REG_DISTINCT, 20'd10);
    push_item(REQ_BUILD, 32'h8000_0000, 32'd0, 1'b0);
    push_item(REQ_BUILD, -32'sd1000, 32'hFFFF_FFFF, 1'b0);
    push_item(REQ_BUILD, -32'sd5, 32'hFFFF_FFFF, 1'b0);
    push_item(REQ_BUILD, 32'd0, 32'd3, 1'b0);
    push_item(REQ_BUILD, 32'd1, 32'd0, 1'b0);
    push_item(REQ_BUILD, 32'd7, 32'd9, 1'b0);
    push_item(REQ_BUILD, 32'd100, 32'h8000_0000, 1'b0);
    push_item(REQ_BUILD, 32'd5000, 32'd1, 1'b0);
    push_item(REQ_BUILD, 32'd70000, 32'd12, 1'b0);
    push_item(REQ_BUILD, 32'h7FFF_FFFE, 32'h7FFF_FFFF, 1'b0);
    push_item(REQ_LOOKUP, 32'h8000_0000, 32'd0, 1'b0);
    push_item(REQ_LOOKUP, -32'sd2, 32'd0, 1'b0);
    push_item(REQ_LOOKUP, 32'd7, 32'd0, 1'b0);
    push_item(REQ_LOOKUP, 32'h7FFF_FFFE, 32'd0, 1'b0);
    push_item(REQ_LOOKUP, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    wait_idle();

    // A lookup in the middle of a build, then a final pair that closes early.
    write_cfg(REG_MAX_BINS, 20'd3);
    write_cfg(REG_DISTINCT, 20'd6);
    push_item(REQ_BUILD, 32'd10, 32'd5, 1'b0);
    push_item(REQ_LOOKUP, 32'd10, 32'd0, 1'b0);
    push_item(REQ_BUILD, 32'd20, 32'd6, 1'b1);
    push_item(REQ_LOOKUP, 32'd15, 32'd0, 1'b0);
    wait_idle();

    phase = 0;
    while (items_pushed < 380) begin
      random_phase(phase);
      phase++;
    end

    // One wide bin of full-scale counts; no idling on either side from here on.
    calm = 1'b1;
    write_cfg(REG_MAX_BINS, 20'd1);
    write_cfg(REG_DISTINCT, 20'd40);
    queue_pairs(40, 1'b0, 1'b0, 1'b1, 0);
    queue_lookups(8);
    wait_idle();

    stop_at = items_pushed + 60;
    while (items_pushed < stop_at) begin
      random_phase(phase);
      phase++;
    end

    if (mismatches == 0) $display("PASS equal_distinct_histogram_engine");
    else $display("FAIL equal_distinct_histogram_engine");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/edh_pkg.sv
sv/edh_front.sv
sv/edh_div.sv
sv/edh_back.sv
sv/equal_distinct_histogram_engine.sv
test/tb_equal_distinct_histogram_engine.sv
